// File: hw/rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Access kinds on the input request
  localparam logic [1:0] MODE_CPU_RD = 2'd0;
  localparam logic [1:0] MODE_CPU_WR = 2'd1;
  localparam logic [1:0] MODE_PPU_RD = 2'd2;
  localparam logic [1:0] MODE_PPU_WR = 2'd3;

  // Target memory codes on the result request
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_PRG  = 3'd1;
  localparam logic [2:0] TGT_SRAM = 3'd2;
  localparam logic [2:0] TGT_CHR  = 3'd3;
  localparam logic [2:0] TGT_NT   = 3'd4;

  // CPU address map
  localparam logic [15:0] REG_BASE   = 16'h7EF0;
  localparam logic [15:0] SRAM_BASE  = 16'h6000;
  localparam logic [15:0] SRAM_END   = 16'h7400;
  localparam logic [13:0] NT_SPACE   = 14'h2000;
  localparam logic [12:0] CHR_HALF   = 13'h1000;
  localparam logic [10:0] NT_SEL_BIT = 11'h0400;
  localparam logic [5:0]  PRG_FIXED  = 6'h3F;

  // Save-RAM unlock bytes
  localparam logic [7:0] RAM0_KEY = 8'hCA;
  localparam logic [7:0] RAM1_KEY = 8'h69;
  localparam logic [7:0] RAM2_KEY = 8'h84;

  // Mapper register offsets from REG_BASE
  localparam logic [3:0] REG_CHR0   = 4'h0;
  localparam logic [3:0] REG_CHR1   = 4'h1;
  localparam logic [3:0] REG_CHR2   = 4'h2;
  localparam logic [3:0] REG_CHR3   = 4'h3;
  localparam logic [3:0] REG_CHR4   = 4'h4;
  localparam logic [3:0] REG_CHR5   = 4'h5;
  localparam logic [3:0] REG_CTRL   = 4'h6;
  localparam logic [3:0] REG_RAMEN0 = 4'h7;
  localparam logic [3:0] REG_RAMEN1 = 4'h8;
  localparam logic [3:0] REG_RAMEN2 = 4'h9;
  localparam logic [3:0] REG_PRG0   = 4'hA;
  localparam logic [3:0] REG_PRG1   = 4'hB;
  localparam logic [3:0] REG_PRG2   = 4'hC;

  // Configuration register indexes
  localparam logic CFG_CHR_PRESENT = 1'b0;

  typedef struct packed {
    logic [2:0][5:0] prg_bank;
    logic [5:0][7:0] chr_bank;
    logic [2:0]      ram_enable;
    logic            mirror_sel;
    logic            chr_invert;
  } cbm_state_t;

  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [7:0] data;
  } cbm_reg_wr_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } cbm_access_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mem_address;
    logic        write_strobe;
    logic [7:0]  pass_data;
  } cbm_result_t;

endpackage

// File: hw/rtl/cbm_xlate.sv
// ----------------------------------------------------------------------------
// cbm_xlate
// Address decode and bank translation of one bus access, plus the decode
// of CPU writes to the mapper registers.
// ----------------------------------------------------------------------------
module cbm_xlate (
  input  cbm_pkg::cbm_access_t acc,
  input  cbm_pkg::cbm_state_t  st,
  input  logic                 chr_present,
  output cbm_pkg::cbm_result_t res,
  output cbm_pkg::cbm_reg_wr_t reg_wr
);

  logic [15:0] a;
  logic [13:0] pa;
  logic [12:0] pat;
  logic        sram_hit;
  logic        sram_en;
  logic [5:0]  prg_sel;
  logic [7:0]  chr_sel;
  logic        nt_bit;

  assign a   = acc.bus_address;
  assign pa  = a[13:0];
  assign pat = pa[12:0] ^ (st.chr_invert ? cbm_pkg::CHR_HALF : 13'h0000);

  assign sram_hit = (a >= cbm_pkg::SRAM_BASE) && (a < cbm_pkg::SRAM_END);
  assign nt_bit   = st.mirror_sel ? pa[10] : pa[11];

  always_comb begin
    case (a[12:11])
      2'd0:    sram_en = st.ram_enable[0];
      2'd1:    sram_en = st.ram_enable[1];
      2'd2:    sram_en = st.ram_enable[2];
      default: sram_en = 1'b0;
    endcase
  end

  always_comb begin
    case (a[14:13])
      2'd0:    prg_sel = st.prg_bank[0];
      2'd1:    prg_sel = st.prg_bank[1];
      2'd2:    prg_sel = st.prg_bank[2];
      default: prg_sel = cbm_pkg::PRG_FIXED;
    endcase
  end

  // Upper pattern half: four 1 KiB banks; lower half: two 2 KiB banks
  always_comb begin
    if (pat[12]) begin
      case (pat[11:10])
        2'd0:    chr_sel = st.chr_bank[2];
        2'd1:    chr_sel = st.chr_bank[3];
        2'd2:    chr_sel = st.chr_bank[4];
        default: chr_sel = st.chr_bank[5];
      endcase
    end else begin
      chr_sel = pat[11] ? st.chr_bank[1] : st.chr_bank[0];
    end
  end

  always_comb begin
    res.target       = cbm_pkg::TGT_NONE;
    res.mem_address  = '0;
    res.write_strobe = 1'b0;
    res.pass_data    = acc.bus_data;
    reg_wr.en        = 1'b0;
    reg_wr.idx       = a[3:0];
    reg_wr.data      = acc.bus_data;
    if (!acc.mode[1]) begin
      if (sram_hit) begin
        if (sram_en) begin
          res.target       = cbm_pkg::TGT_SRAM;
          res.mem_address  = {6'd0, a[12:0]};
          res.write_strobe = (acc.mode == cbm_pkg::MODE_CPU_WR);
        end
      end else if (acc.mode == cbm_pkg::MODE_CPU_WR) begin
        reg_wr.en = (a[15:4] == cbm_pkg::REG_BASE[15:4]) && (a[3:0] <= cbm_pkg::REG_PRG2);
      end else if (a[15]) begin
        res.target      = cbm_pkg::TGT_PRG;
        res.mem_address = {prg_sel, a[12:0]};
      end
    end else begin
      if ((pa & cbm_pkg::NT_SPACE) != 14'd0) begin
        res.target       = cbm_pkg::TGT_NT;
        res.mem_address  = {8'd0, (nt_bit ? cbm_pkg::NT_SEL_BIT : 11'd0) | {1'b0, pa[9:0]}};
        res.write_strobe = (acc.mode == cbm_pkg::MODE_PPU_WR);
      end else if ((acc.mode == cbm_pkg::MODE_PPU_RD) && chr_present) begin
        res.target = cbm_pkg::TGT_CHR;
        if (pat[12]) begin
          res.mem_address = {1'b0, chr_sel, pat[9:0]};
        end else begin
          res.mem_address = {chr_sel, pat[10:0]};
        end
      end
    end
  end

endmodule

// File: hw/rtl/cbm_regs.sv
// ----------------------------------------------------------------------------
// cbm_regs
// Mapper bank, mode and save-RAM enable registers, written by CPU requests.
// ----------------------------------------------------------------------------
module cbm_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cbm_pkg::cbm_reg_wr_t wr,
  output cbm_pkg::cbm_state_t  st
);

  cbm_pkg::cbm_state_t st_r;

  assign st = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (wr.en) begin
      unique case (wr.idx)
        cbm_pkg::REG_CHR0:   st_r.chr_bank[0] <= {1'b0, wr.data[7:1]};
        cbm_pkg::REG_CHR1:   st_r.chr_bank[1] <= {1'b0, wr.data[7:1]};
        cbm_pkg::REG_CHR2:   st_r.chr_bank[2] <= wr.data;
        cbm_pkg::REG_CHR3:   st_r.chr_bank[3] <= wr.data;
        cbm_pkg::REG_CHR4:   st_r.chr_bank[4] <= wr.data;
        cbm_pkg::REG_CHR5:   st_r.chr_bank[5] <= wr.data;
        cbm_pkg::REG_CTRL: begin
          st_r.mirror_sel <= wr.data[0];
          st_r.chr_invert <= wr.data[1];
        end
        cbm_pkg::REG_RAMEN0: st_r.ram_enable[0] <= (wr.data == cbm_pkg::RAM0_KEY);
        cbm_pkg::REG_RAMEN1: st_r.ram_enable[1] <= (wr.data == cbm_pkg::RAM1_KEY);
        cbm_pkg::REG_RAMEN2: st_r.ram_enable[2] <= (wr.data == cbm_pkg::RAM2_KEY);
        cbm_pkg::REG_PRG0:   st_r.prg_bank[0] <= wr.data[7:2];
        cbm_pkg::REG_PRG1:   st_r.prg_bank[1] <= wr.data[7:2];
        cbm_pkg::REG_PRG2:   st_r.prg_bank[2] <= wr.data[7:2];
        default: begin
          // offsets past the last register hold state
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/cart_bank_mapper.sv
// ----------------------------------------------------------------------------
// cart_bank_mapper
// An accepted request passes through the input register, then the result register.
// Throughput: one request per cycle while the result sink is ready, set by the input and result registers.
// Mapper registers written by a request steer every later request.
// Reset (synchronous, rst_n low): banks, enables and modes clear to zero,
// character ROM is marked present, both pipeline registers empty.
// ----------------------------------------------------------------------------
module cart_bank_mapper (
  input  logic        clk,
  input  logic        rst_n,
  // input request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] bus_address, [23:16] bus_data
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [18:0] mem_address, [19] write_strobe,
                                  // [27:20] pass_data, [31:28] zero
  output logic [2:0]  out_tuser,  // [2:0] target
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cbm_pkg::cbm_access_t acc_r;
  logic                 acc_valid_r;
  cbm_pkg::cbm_result_t res_r;
  logic                 res_valid_r;
  logic                 chr_present_r;

  cbm_pkg::cbm_result_t res_nxt;
  cbm_pkg::cbm_reg_wr_t reg_wr;
  cbm_pkg::cbm_reg_wr_t reg_wr_gated;
  cbm_pkg::cbm_state_t  st;
  logic                 res_load;
  logic                 cfg_wr;

  // Move the held request into the result register when that slot frees up
  assign res_load  = acc_valid_r && (!res_valid_r || out_tready);
  // Take a new request whenever the input register empties this cycle
  assign in_tready = !acc_valid_r || res_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        acc_valid_r <= in_tvalid;
      end
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (out_tready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      acc_r.mode        <= in_tuser;
      acc_r.bus_address <= in_tdata[15:0];
      acc_r.bus_data    <= in_tdata[23:16];
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  cbm_xlate u_xlate (
    .acc         (acc_r),
    .st          (st),
    .chr_present (chr_present_r),
    .res         (res_nxt),
    .reg_wr      (reg_wr)
  );

  // Commit a register write only when its request advances, so each
  // request is decoded against the state left by the one before it
  always_comb begin
    reg_wr_gated    = reg_wr;
    reg_wr_gated.en = reg_wr.en && res_load;
  end

  cbm_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (reg_wr_gated),
    .st    (st)
  );

  assign out_tvalid = res_valid_r;
  assign out_tuser  = res_r.target;
  assign out_tdata  = {4'd0, res_r.pass_data, res_r.write_strobe, res_r.mem_address};

  // Configuration port: one register, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chr_present_r <= 1'b1;
    end else if (cfg_wr && (cfg_paddr[2] == cbm_pkg::CFG_CHR_PRESENT)) begin
      chr_present_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == cbm_pkg::CFG_CHR_PRESENT) ?
                      {31'd0, chr_present_r} : 32'd0;

endmodule

// File: hw/rtl/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the cartridge bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module cbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // Result codes stay within the defined targets
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= cbm_pkg::TGT_NT))
    else $error("result target code out of range");

  // No target means no address and no write
  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == cbm_pkg::TGT_NONE)) |-> (out_tdata[19:0] == 20'd0))
    else $error("open-bus result carries address or strobe");

  // Only writable memories get a write strobe
  a_strobe_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[19]) |->
      ((out_tuser == cbm_pkg::TGT_SRAM) || (out_tuser == cbm_pkg::TGT_NT)))
    else $error("write strobe on read-only target");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result request changed");

endmodule

bind cart_bank_mapper cbm_checker u_cbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: bench/cart_bank_mapper_tb.sv
// ----------------------------------------------------------------------------
// cart_bank_mapper_tb
// Self-checking bench for the cartridge bank mapper. A clocked driver feeds
// bus-access requests from a queue, and a bit-accurate predictor tracks the
// mapper registers and works out the target, address, strobe and data of
// every accepted access. A clocked monitor checks each result request, field
// by field, against the oldest prediction. Phases vary the character ROM
// setting and the amount of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module cart_bank_mapper_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  // Clock, reset and block ports; every input starts at a known value
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;   // [15:0] bus_address, [23:16] bus_data
  logic [1:0]  in_tuser    = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [18:0] mem_address, [19] write_strobe,
                                   // [27:20] pass_data, [31:28] zero
  logic [2:0]  out_tuser;          // [2:0] target
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Requests waiting for the driver, and mappings waiting for the monitor
  cbm_access_t pending_accesses[$];
  cbm_result_t expected_maps[$];

  // Predictor copy of the mapper state and the configuration
  logic [5:0] prg_bank_q [3] = '{default: '0};
  logic [7:0] chr_bank_q [6] = '{default: '0};
  logic       ram_en_q   [3] = '{default: '0};
  logic       mirror_q        = 1'b0;
  logic       invert_q        = 1'b0;
  logic       chr_present_q   = 1'b1;

  // Flow control knobs, in percent per cycle
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req       = 1'b0;
  int unsigned recv_hold_left = 0;

  // Bookkeeping
  int unsigned mismatch_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned phases_run   = 0;
  int unsigned tgt_seen [5] = '{default: 0};

  cart_bank_mapper i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: translate one bus access and apply any mapper register write.
  // Call it once per accepted request, in acceptance order.
  // --------------------------------------------------------------------------
  function automatic cbm_result_t map_access(cbm_access_t acc);
    cbm_result_t res;
    logic [15:0] a;
    logic [7:0]  d;
    logic [13:0] pa;
    logic [13:0] nt_sel;
    logic [12:0] pat;
    logic [5:0]  bank;
    a = acc.bus_address;
    d = acc.bus_data;
    res.target       = TGT_NONE;
    res.mem_address  = '0;
    res.write_strobe = 1'b0;
    res.pass_data    = d;
    if (acc.mode == MODE_CPU_RD || acc.mode == MODE_CPU_WR) begin
      if (a >= SRAM_BASE && a < SRAM_END) begin
        // Save RAM: 2 KiB, 2 KiB and 1 KiB windows, each with its own enable
        if (ram_en_q[a[12:11]]) begin
          res.target       = TGT_SRAM;
          res.mem_address  = 19'(a[12:0]);
          res.write_strobe = (acc.mode == MODE_CPU_WR);
        end
      end else if (acc.mode == MODE_CPU_WR) begin
        // Only the mapper register block reacts; everything else is dropped
        if (a[15:4] == REG_BASE[15:4]) begin
          case (a[3:0])
            REG_CHR0:   chr_bank_q[0] = d >> 1;
            REG_CHR1:   chr_bank_q[1] = d >> 1;
            REG_CHR2:   chr_bank_q[2] = d;
            REG_CHR3:   chr_bank_q[3] = d;
            REG_CHR4:   chr_bank_q[4] = d;
            REG_CHR5:   chr_bank_q[5] = d;
            REG_CTRL: begin
              mirror_q = d[0];
              invert_q = d[1];
            end
            REG_RAMEN0: ram_en_q[0] = (d == RAM0_KEY);
            REG_RAMEN1: ram_en_q[1] = (d == RAM1_KEY);
            REG_RAMEN2: ram_en_q[2] = (d == RAM2_KEY);
            REG_PRG0:   prg_bank_q[0] = d[7:2];
            REG_PRG1:   prg_bank_q[1] = d[7:2];
            REG_PRG2:   prg_bank_q[2] = d[7:2];
            default: ;
          endcase
        end
      end else if (a[15]) begin
        // Three switchable 8 KiB windows, plus a top one fixed to the last bank
        bank = (a[14:13] == 2'd3) ? PRG_FIXED : prg_bank_q[a[14:13]];
        res.target      = TGT_PRG;
        res.mem_address = {bank, a[12:0]};
      end
    end else begin
      pa = a[13:0];
      if ((pa & NT_SPACE) != '0) begin
        nt_sel = mirror_q ? pa : (pa >> 1);
        res.target       = TGT_NT;
        res.mem_address  = 19'((nt_sel & 14'(NT_SEL_BIT)) | (pa & 14'h03FF));
        res.write_strobe = (acc.mode == MODE_PPU_WR);
      end else if (acc.mode == MODE_PPU_RD && chr_present_q) begin
        pat = pa[12:0];
        if (invert_q) pat = pat ^ CHR_HALF;
        res.target = TGT_CHR;
        if (pat < 13'h0800)
          res.mem_address = {chr_bank_q[0], pat[10:0]};
        else if (pat < CHR_HALF)
          res.mem_address = {chr_bank_q[1], pat[10:0]};
        else
          res.mem_address = 19'({chr_bank_q[2 + pat[11:10]], pat[9:0]});
      end
    end
    return res;
  endfunction

  function automatic cbm_access_t mk_access(logic [1:0] m, logic [15:0] a, logic [7:0] d);
    return '{mode: m, bus_address: a, bus_data: d};
  endfunction

  function automatic logic [15:0] reg_addr(logic [3:0] r);
    return REG_BASE | 16'(r);
  endfunction

  // Random access mix: mostly mapper setup and mapped windows, some noise
  function automatic cbm_access_t random_access();
    cbm_access_t acc;
    int unsigned pick;
    logic [3:0]  r;
    pick            = $urandom_range(0, 99);
    acc.mode        = 2'($urandom);
    acc.bus_address = 16'($urandom);
    acc.bus_data    = 8'($urandom);
    if (pick < 22) begin
      // Mapper register write; half the enable writes carry the unlock byte
      r               = 4'($urandom_range(0, int'(REG_PRG2)));
      acc.mode        = MODE_CPU_WR;
      acc.bus_address = reg_addr(r);
      if ($urandom_range(0, 1) == 1) begin
        case (r)
          REG_RAMEN0: acc.bus_data = RAM0_KEY;
          REG_RAMEN1: acc.bus_data = RAM1_KEY;
          REG_RAMEN2: acc.bus_data = RAM2_KEY;
          default: ;
        endcase
      end
    end else if (pick < 40) begin
      acc.mode        = ($urandom_range(0, 1) == 1) ? MODE_CPU_WR : MODE_CPU_RD;
      acc.bus_address = 16'($urandom_range(int'(SRAM_BASE), int'(SRAM_END) - 1));
    end else if (pick < 55) begin
      acc.mode            = MODE_CPU_RD;
      acc.bus_address[15] = 1'b1;
    end else if (pick < 62) begin
      // Anywhere in CPU space, reads and writes alike
      acc.mode = ($urandom_range(0, 1) == 1) ? MODE_CPU_WR : MODE_CPU_RD;
    end else if (pick < 80) begin
      acc.mode            = MODE_PPU_RD;
      acc.bus_address[13] = 1'b0;
    end else begin
      acc.mode = ($urandom_range(0, 1) == 1) ? MODE_PPU_WR : MODE_PPU_RD;
    end
    return acc;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict on every accepted request, then offer the next one or
  // idle at random. Hold the current request until it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_accesses
    cbm_access_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_maps.push_back(map_access(cbm_access_t'({in_tuser, in_tdata[15:0],
                                                          in_tdata[23:16]})));
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt       = pending_accesses.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.mode;
          in_tdata  <= {nxt.bus_data, nxt.bus_address};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long sink hold-off, counted here so the stimulus only has to kick it
  always @(posedge clk) begin : recv_hold_timer
    if (hold_req)
      recv_hold_left <= 64;
    else if (recv_hold_left != 0)
      recv_hold_left <= recv_hold_left - 1;
  end

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check every accepted result request against the oldest
  // prediction, then pick the next ready value.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    cbm_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_maps.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result request with no access outstanding (target %0d)",
                     $realtime, out_tuser);
        end else begin
          want = expected_maps.pop_front();
          checked_cnt++;
          if (out_tuser < 5) tgt_seen[out_tuser]++;
          if (out_tuser != want.target)
            note_mismatch("target", want.target, out_tuser);
          if (out_tdata[18:0] != want.mem_address)
            note_mismatch("mem_address", want.mem_address, out_tdata[18:0]);
          if (out_tdata[19] != want.write_strobe)
            note_mismatch("write_strobe", want.write_strobe, out_tdata[19]);
          if (out_tdata[27:20] != want.pass_data)
            note_mismatch("pass_data", want.pass_data, out_tdata[27:20]);
          if (out_tdata[31:28] != 4'd0)
            note_mismatch("tdata padding", 0, out_tdata[31:28]);
        end
      end
      out_tready <= (recv_hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Settle at the falling edge, where queues and handshakes are stable
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_accesses.size() != 0 || in_tvalid || expected_maps.size() != 0);
  endtask

  // Write the character ROM present bit; call only with no access in flight
  task automatic set_chr_present(input logic v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * CFG_CHR_PRESENT);
    cfg_pwdata  <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    chr_present_q = v;
  endtask

  // One random phase; optionally stall the sink for a long stretch at the
  // start, or pause the source halfway until every result is back.
  task automatic run_phase(input logic chr, input int unsigned send_pct,
                           input int unsigned recv_pct, input int unsigned count,
                           input bit long_hold, input bit mid_pause);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    set_chr_present(chr);
    for (int unsigned i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) wait_drained();
      pending_accesses.push_back(random_access());
    end
    if (long_hold) begin
      @(posedge clk);
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
    end
    wait_drained();
    phases_run++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : run_phases
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: windows at reset, unlock every save RAM bank, load banks,
    // swap pattern halves, both mirroring modes, ignored writes.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_chr_present(1'b1);
    pending_accesses.push_back(mk_access(MODE_CPU_RD, 16'h8000, 8'h00));
    pending_accesses.push_back(mk_access(MODE_CPU_RD, 16'hFFFF, 8'hFF));
    pending_accesses.push_back(mk_access(MODE_CPU_RD, 16'h0000, 8'h5A));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, SRAM_BASE, 8'hA5));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_RAMEN0), RAM0_KEY));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_RAMEN1), RAM1_KEY));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_RAMEN2), RAM2_KEY));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_PRG0), 8'hFF));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_PRG1), 8'h55));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_CHR0), 8'hFF));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_CHR5), 8'h80));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_CTRL), 8'h03));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, SRAM_BASE, 8'hFF));
    pending_accesses.push_back(mk_access(MODE_CPU_RD, SRAM_END - 16'd1, 8'h00));
    pending_accesses.push_back(mk_access(MODE_CPU_RD, SRAM_END, 8'h3C));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_PRG2) + 16'd1, 8'hFF));
    pending_accesses.push_back(mk_access(MODE_CPU_RD, 16'hBFFF, 8'h00));
    pending_accesses.push_back(mk_access(MODE_PPU_RD, 16'h0000, 8'h00));
    // address bits above 13 must not matter
    pending_accesses.push_back(mk_access(MODE_PPU_RD, 16'hDFFF, 8'hC3));
    pending_accesses.push_back(mk_access(MODE_PPU_WR, 16'h0800, 8'h77));
    pending_accesses.push_back(mk_access(MODE_PPU_WR, 16'hFFFF, 8'hFF));
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_CTRL), 8'h00));
    pending_accesses.push_back(mk_access(MODE_PPU_RD, 16'h2C00, 8'h00));
    // any byte other than the key locks the bank again
    pending_accesses.push_back(mk_access(MODE_CPU_WR, reg_addr(REG_RAMEN1), 8'h68));
    pending_accesses.push_back(mk_access(MODE_CPU_RD, 16'h6800, 8'h99));
    wait_drained();
    phases_run++;

    // Random phases: no character ROM with a slow source, a long sink stall,
    // mixed idling with a full drain halfway, then full rate.
    run_phase(1'b0, 49, 0,  190, 1'b0, 1'b0);
    run_phase(1'b1, 0,  49, 190, 1'b1, 1'b0);
    run_phase(1'b0, 14, 14, 190, 1'b0, 1'b1);
    run_phase(1'b1, 0,  0,  180, 1'b0, 1'b0);

    // Let the pipeline settle before the verdict
    repeat (8) @(posedge clk);
    $display("Checked %0d of %0d accesses over %0d phases, both ROM settings.",
             checked_cnt, accepted_cnt, phases_run);
    $display("Targets seen: none %0d, prg %0d, sram %0d, chr %0d, nametable %0d.",
             tgt_seen[0], tgt_seen[1], tgt_seen[2], tgt_seen[3], tgt_seen[4]);
    if (mismatch_cnt == 0) begin
      $display("** cart_bank_mapper: PASSED **");
    end else begin
      $display("%0d mismatches in total", mismatch_cnt);
      $display("** cart_bank_mapper: FAILED **");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #500us;
    $display("Timeout with %0d results outstanding", expected_maps.size());
    $display("** cart_bank_mapper: FAILED **");
    $finish;
  end

endmodule
